### hw/rtl/pfe_pkg.sv
// Package for the postfix expression evaluator: token codes, status codes,
// queue entry and operation types. No dependencies.
package pfe_pkg;

   localparam int DefaultStackDepth = 16;
   localparam int WordWidth = 32;
   localparam int TokenWidth = 8;
   localparam int StatusWidth = 3;

   localparam logic [TokenWidth-1:0] TokPlus = 8'h2B;
   localparam logic [TokenWidth-1:0] TokMinus = 8'h2D;
   localparam logic [TokenWidth-1:0] TokMul = 8'h2A;
   localparam logic [TokenWidth-1:0] TokDiv = 8'h2F;
   localparam logic [TokenWidth-1:0] TokPow = 8'h5E;
   localparam logic [TokenWidth-1:0] DigitBias = 8'd48;

   localparam logic [StatusWidth-1:0] StOk = 3'd0;
   localparam logic [StatusWidth-1:0] StUnderflow = 3'd1;
   localparam logic [StatusWidth-1:0] StOverflow = 3'd2;
   localparam logic [StatusWidth-1:0] StDivZero = 3'd3;
   localparam logic [StatusWidth-1:0] StZeroNeg = 3'd4;

   typedef enum logic [2:0] {
      OpPush = 3'd0,
      OpAdd = 3'd1,
      OpSub = 3'd2,
      OpMul = 3'd3,
      OpDiv = 3'd4,
      OpPow = 3'd5
   } op_type;

   typedef struct packed {
      op_type op;
      logic [WordWidth-1:0] imm;
      logic last;
   } cmd_type;

endpackage

### hw/rtl/postfix_expression_evaluator_unit.sv
// Postfix evaluator top level: front end classifies tokens into a two-entry
// queue, back end runs the stack machine. The back end divides with one
// quotient bit a cycle and raises powers in two steps per exponent bit; a last
// token adds an emit step before the result shows.
// Synchronous active-high reset empties the stack and clears the error.
module postfix_expression_evaluator_unit #(
   parameter int StackDepth = pfe_pkg::DefaultStackDepth
) (
   input logic clock,
   input logic reset,
   input logic req_valid,
   output logic req_stall,
   input logic [pfe_pkg::TokenWidth-1:0] req_token,
   input logic req_last,
   output logic rsp_valid,
   input logic rsp_stall,
   output logic signed [pfe_pkg::WordWidth-1:0] rsp_value,
   output logic [pfe_pkg::StatusWidth-1:0] rsp_status
);
   import pfe_pkg::*;

   logic cmd_valid;
   logic cmd_take;
   cmd_type cmd;

   pfe_front u_front (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_token(req_token), .req_last(req_last),
      .cmd_valid(cmd_valid), .cmd_take(cmd_take), .cmd(cmd)
   );

   pfe_back #(.StackDepth(StackDepth)) u_back (
      .clock(clock), .reset(reset),
      .cmd_valid(cmd_valid), .cmd_take(cmd_take), .cmd(cmd),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_value(rsp_value), .rsp_status(rsp_status)
   );
endmodule

### hw/rtl/pfe_front.sv
// Front end: accepts tokens, classifies them into commands, holds a
// two-entry queue toward the back end. Depends on pfe_pkg.
module pfe_front (
   input logic clock,
   input logic reset,
   input logic req_valid,
   output logic req_stall,
   input logic [pfe_pkg::TokenWidth-1:0] req_token,
   input logic req_last,
   output logic cmd_valid,
   input logic cmd_take,
   output pfe_pkg::cmd_type cmd
);
   import pfe_pkg::*;

   cmd_type q_ff [2];
   cmd_type q_in;
   logic [1:0] cnt_ff;
   logic [1:0] cnt_in;
   logic rd_ff;
   logic wr_ff;
   logic push;
   logic pop;

   always_comb begin
      q_in.last = req_last;
      q_in.imm = {{(WordWidth-TokenWidth){1'b0}}, req_token - DigitBias};
      if (req_token < DigitBias) begin
         q_in.imm = {{(WordWidth-TokenWidth){1'b1}}, req_token - DigitBias};
      end
      unique case (req_token)
         TokPlus: q_in.op = OpAdd;
         TokMinus: q_in.op = OpSub;
         TokMul: q_in.op = OpMul;
         TokDiv: q_in.op = OpDiv;
         TokPow: q_in.op = OpPow;
         default: q_in.op = OpPush;
      endcase
   end

   assign req_stall = (cnt_ff == 2'd2);
   assign push = req_valid && !req_stall;
   assign pop = cmd_valid && cmd_take;
   assign cmd_valid = (cnt_ff != 2'd0);
   assign cmd = q_ff[rd_ff];
   assign cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ff] <= q_in;
      end
      if (reset) begin
         cnt_ff <= 2'd0;
         rd_ff <= 1'b0;
         wr_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         if (push) wr_ff <= !wr_ff;
         if (pop) rd_ff <= !rd_ff;
      end
   end
endmodule

### hw/rtl/pfe_back.sv
// Back end: operand stack, sequencer, iterative divider and power unit,
// and the result register. Depends on pfe_pkg.
module pfe_back #(
   parameter int StackDepth = pfe_pkg::DefaultStackDepth
) (
   input logic clock,
   input logic reset,
   input logic cmd_valid,
   output logic cmd_take,
   input pfe_pkg::cmd_type cmd,
   output logic rsp_valid,
   input logic rsp_stall,
   output logic signed [pfe_pkg::WordWidth-1:0] rsp_value,
   output logic [pfe_pkg::StatusWidth-1:0] rsp_status
);
   import pfe_pkg::*;

   localparam int PtrWidth = $clog2(StackDepth + 1);
   localparam int AddrWidth = $clog2(StackDepth);
   localparam int CntWidth = $clog2(WordWidth + 1);

   typedef enum logic [6:0] {
      SIdle = 7'b0000001,
      SRead = 7'b0000010,
      SExec = 7'b0000100,
      SDiv = 7'b0001000,
      SPow = 7'b0010000,
      SPush = 7'b0100000,
      SEmit = 7'b1000000
   } state_type;

   logic [WordWidth-1:0] mem [StackDepth];
   logic [WordWidth-1:0] top_ff;
   logic [WordWidth-1:0] rd_ff;
   state_type state_ff;
   state_type state_in;
   logic [PtrWidth-1:0] sp_ff;
   logic [StatusWidth-1:0] err_ff;
   cmd_type cmd_ff;
   logic [WordWidth-1:0] b_ff;
   logic [WordWidth-1:0] res_ff;
   logic [WordWidth-1:0] rem_ff;
   logic [WordWidth-1:0] quo_ff;
   logic [WordWidth-1:0] acc_ff;
   logic [WordWidth-1:0] sq_ff;
   logic [WordWidth-1:0] ex_ff;
   logic neg_ff;
   logic mul_ph_ff;
   logic popped_ff;
   logic [CntWidth-1:0] cnt_ff;
   logic out_valid_ff;
   logic [WordWidth-1:0] out_value_ff;
   logic [StatusWidth-1:0] out_status_ff;
   logic [WordWidth-1:0] mag_b;
   logic [WordWidth:0] trial;
   logic [WordWidth-1:0] rem_sh;
   logic [StatusWidth-1:0] err_push;
   logic full;
   logic emit_go;
   logic push_go;

   assign mag_b = b_ff[WordWidth-1] ? (~b_ff + 1'b1) : b_ff;
   assign rem_sh = {rem_ff[WordWidth-2:0], quo_ff[WordWidth-1]};
   assign trial = {1'b0, rem_sh} - {1'b0, mag_b};
   assign full = (sp_ff >= PtrWidth'(StackDepth));
   assign err_push = (err_ff == StOk && full) ? StOverflow : err_ff;
   assign cmd_take = (state_ff == SIdle) && cmd_valid;
   assign emit_go = (state_ff == SEmit) && (!out_valid_ff || !rsp_stall);
   assign push_go = (state_ff == SPush) && (cmd_ff.op == OpPush || popped_ff);
   assign rsp_valid = out_valid_ff;
   assign rsp_value = out_value_ff;
   assign rsp_status = out_status_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         SIdle: if (cmd_valid) state_in = (cmd.op == OpPush) ? SPush : SRead;
         SRead: state_in = SExec;
         SExec: begin
            if (sp_ff < PtrWidth'(2)) state_in = SPush;
            else if (cmd_ff.op == OpDiv && top_ff != '0) state_in = SDiv;
            else if (cmd_ff.op == OpPow && !top_ff[WordWidth-1]) state_in = SPow;
            else state_in = SPush;
         end
         SDiv: if (cnt_ff == CntWidth'(WordWidth)) state_in = SPush;
         SPow: if (ex_ff == '0 && !mul_ph_ff) state_in = SPush;
         SPush: state_in = cmd_ff.last ? SEmit : SIdle;
         SEmit: if (emit_go) state_in = SIdle;
         default: state_in = SIdle;
      endcase
   end

   always_ff @(posedge clock) begin
      if (state_ff == SRead) begin
         rd_ff <= mem[AddrWidth'(sp_ff - PtrWidth'(2))];
      end
      unique case (state_ff)
         SIdle: begin
            cmd_ff <= cmd;
            res_ff <= cmd.imm;
         end
         SExec: begin
            b_ff <= top_ff;
            popped_ff <= (sp_ff >= PtrWidth'(2));
            neg_ff <= rd_ff[WordWidth-1] ^ top_ff[WordWidth-1];
            quo_ff <= rd_ff[WordWidth-1] ? (~rd_ff + 1'b1) : rd_ff;
            rem_ff <= '0;
            cnt_ff <= '0;
            acc_ff <= {{(WordWidth-1){1'b0}}, 1'b1};
            sq_ff <= rd_ff;
            ex_ff <= top_ff;
            mul_ph_ff <= 1'b0;
            case (cmd_ff.op)
               OpAdd: res_ff <= rd_ff + top_ff;
               OpSub: res_ff <= rd_ff - top_ff;
               OpMul: res_ff <= rd_ff * top_ff;
               OpDiv: res_ff <= '0;
               default: begin
                  if (rd_ff == {{(WordWidth-1){1'b0}}, 1'b1}) res_ff <= rd_ff;
                  else if (rd_ff == '1) res_ff <= top_ff[0] ? '1 : 32'd1;
                  else res_ff <= '0;
               end
            endcase
         end
         SDiv: begin
            if (cnt_ff == CntWidth'(WordWidth)) begin
               res_ff <= neg_ff ? (~quo_ff + 1'b1) : quo_ff;
            end else begin
               cnt_ff <= cnt_ff + 1'b1;
               if (!trial[WordWidth]) begin
                  rem_ff <= trial[WordWidth-1:0];
                  quo_ff <= {quo_ff[WordWidth-2:0], 1'b1};
               end else begin
                  rem_ff <= rem_sh;
                  quo_ff <= {quo_ff[WordWidth-2:0], 1'b0};
               end
            end
         end
         SPow: begin
            mul_ph_ff <= !mul_ph_ff;
            if (!mul_ph_ff) begin
               if (ex_ff == '0) res_ff <= acc_ff;
               else if (ex_ff[0]) acc_ff <= acc_ff * sq_ff;
            end else begin
               sq_ff <= sq_ff * sq_ff;
               ex_ff <= ex_ff >> 1;
            end
         end
         default: ;
      endcase
      if (push_go && !full) begin
         mem[AddrWidth'(sp_ff)] <= res_ff;
         top_ff <= res_ff;
      end
      if (emit_go) begin
         out_value_ff <= (sp_ff == '0) ? '0 : top_ff;
         out_status_ff <= (err_ff == StOk && sp_ff == '0) ? StUnderflow : err_ff;
      end

      if (reset) begin
         state_ff <= SIdle;
         sp_ff <= '0;
         err_ff <= StOk;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (emit_go) out_valid_ff <= 1'b1;
         else if (out_valid_ff && !rsp_stall) out_valid_ff <= 1'b0;
         if (state_ff == SExec) begin
            if (sp_ff >= PtrWidth'(2)) sp_ff <= sp_ff - PtrWidth'(2);
            if (err_ff == StOk) begin
               if (sp_ff < PtrWidth'(2)) err_ff <= StUnderflow;
               else if (cmd_ff.op == OpDiv && top_ff == '0) err_ff <= StDivZero;
               else if (cmd_ff.op == OpPow && top_ff[WordWidth-1] && rd_ff == '0) begin
                  err_ff <= StZeroNeg;
               end
            end
         end
         if (push_go) begin
            if (!full) sp_ff <= sp_ff + 1'b1;
            err_ff <= err_push;
         end
         if (emit_go) begin
            sp_ff <= '0;
            err_ff <= StOk;
         end
      end
   end
endmodule

### hw/rtl/pfe_checker.sv
// Port-level checker for the postfix evaluator, bound to the top level.
// Depends on pfe_pkg.
module pfe_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_stall,
   input logic rsp_valid,
   input logic rsp_stall,
   input logic [pfe_pkg::WordWidth-1:0] rsp_value,
   input logic [pfe_pkg::StatusWidth-1:0] rsp_status
);
   import pfe_pkg::*;

   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status <= StZeroNeg)) else $error("bad status");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_value)
      && $stable(rsp_status)) else $error("result changed under stall");

   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> req_valid) else $error("request dropped under stall");

   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid) else $error("result after reset");
endmodule

bind postfix_expression_evaluator_unit pfe_checker u_checker (
   .clock(clock), .reset(reset),
   .req_valid(req_valid), .req_stall(req_stall),
   .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
   .rsp_value(rsp_value), .rsp_status(rsp_status)
);
